// File: rtl/olist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// Shared codes, types and helpers for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int DW = 32;

  typedef logic [DW-1:0] word_t;

  // request codes
  localparam logic [3:0] OP_SORTED_INS = 4'd0;
  localparam logic [3:0] OP_HEAD_INS   = 4'd1;
  localparam logic [3:0] OP_TAIL_INS   = 4'd2;
  localparam logic [3:0] OP_RMV_VALUE  = 4'd3;
  localparam logic [3:0] OP_RMV_HEAD   = 4'd4;
  localparam logic [3:0] OP_RMV_TAIL   = 4'd5;
  localparam logic [3:0] OP_FIND       = 4'd6;
  localparam logic [3:0] OP_BUMP       = 4'd7;
  localparam logic [3:0] OP_SORT       = 4'd8;
  localparam logic [3:0] OP_REVERSE    = 4'd9;
  localparam logic [3:0] OP_CLEAR      = 4'd10;
  localparam logic [3:0] OP_READ       = 4'd11;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // per-cell update codes
  localparam logic [2:0] CELL_HOLD  = 3'd0;
  localparam logic [2:0] CELL_LOAD  = 3'd1;  // take the request value
  localparam logic [2:0] CELL_LEFT  = 3'd2;  // take the head-side neighbor
  localparam logic [2:0] CELL_RIGHT = 3'd3;  // take the tail-side neighbor
  localparam logic [2:0] CELL_INC   = 3'd4;  // add one, wrapping
  localparam logic [2:0] CELL_LO    = 3'd5;  // lower cell of a transposition pair
  localparam logic [2:0] CELL_HI    = 3'd6;  // upper cell of a transposition pair

  typedef struct packed {
    logic [2:0] op;
    logic       force_swap;
  } cell_ctl_t;

  function automatic logic less_s(word_t a, word_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// File: rtl/olist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_cell
// One list slot: holds a value, compares it and trades it with neighbors.
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                 clk,
  input  olist_pkg::cell_ctl_t ctl,
  input  olist_pkg::word_t     ins_val,
  input  olist_pkg::word_t     left_val,
  input  olist_pkg::word_t     right_val,
  input  logic                 right_swap,
  output olist_pkg::word_t     val,
  output logic                 swap_req,
  output logic                 lt_v,
  output logic                 eq_v
);
  import olist_pkg::*;

  word_t val_r;
  word_t val_nxt;

  // swap_req: this cell sorts below its head-side neighbor
  assign swap_req = less_s(val_r, left_val);
  assign lt_v     = less_s(val_r, ins_val);
  assign eq_v     = (val_r == ins_val);
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_HOLD:  val_nxt = val_r;
      CELL_LOAD:  val_nxt = ins_val;
      CELL_LEFT:  val_nxt = left_val;
      CELL_RIGHT: val_nxt = right_val;
      CELL_INC:   val_nxt = val_r + word_t'(1);
      CELL_LO: begin
        if (ctl.force_swap || right_swap) val_nxt = right_val;
      end
      CELL_HI: begin
        if (ctl.force_swap || swap_req) val_nxt = left_val;
      end
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/olist_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_locate
// Finds the first set stop flag: one-hot, at-or-after mask and position.
// ----------------------------------------------------------------------------
module olist_locate #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0]         stop,
  output logic [DEPTH-1:0]         first,
  output logic [DEPTH-1:0]         ge,
  output logic [$clog2(DEPTH)-1:0] pos,
  output logic                     hit
);
  import olist_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [DEPTH-1:0] pre;

  // log-depth prefix OR toward the tail
  always_comb begin
    pre = stop;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      pre = pre | (pre << s);
    end
  end

  assign ge    = pre;
  assign first = pre & ~(pre << 1);
  assign hit   = pre[DEPTH-1];

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) pos = pos | PW'(i);
    end
  end

endmodule

// File: rtl/ordered_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded list of signed 32-bit values held in a row of cells plus a count.
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer when       | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid & in_ready | operation, value, index
//  out_    | output    | out_valid&out_ready | data_out, found, where_found,
//          |           |                     | count, status
//
//  Steps: insert, remove and find go through accept, per-cell compare and
//  shift. Bump, clear, read and unused codes go through accept, compare and
//  a finish step. Sort and reverse, when the list holds two or more elements,
//  add one odd-even transposition round across the cell row per element.
//  Reset: synchronous rst_n low empties the list; cell contents are not
//  cleared, only positions below the count are ever read.
//  Stalls: a new request is taken while a result still waits; the final
//  update of that request holds until the output register is free.
//
module ordered_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        in_operation,
  input  logic signed [31:0] in_value,
  input  logic [3:0]        in_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [31:0] out_data_out,
  output logic              out_found,
  output logic [3:0]        out_where_found,
  output logic [4:0]        out_count,
  output logic [1:0]        out_status
);
  import olist_pkg::*;

  localparam int LW = $clog2(DEPTH + 1);     // count width
  localparam int PW = $clog2(DEPTH);         // position width
  localparam int CW = (LW > 4) ? LW : 4;     // index vs count compare width
  localparam int RN = 16;                    // positions the read index reaches

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_PASS   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    pass_r, pass_nxt;
  logic [3:0]       op_r;
  word_t            val_r;
  logic [3:0]       idx_r;
  logic [DEPTH-1:0] stop_r, stop_nxt;

  logic             out_valid_r, out_valid_nxt;
  word_t            data_r, data_nxt;
  logic             found_r, found_nxt;
  logic [3:0]       where_r, where_nxt;
  logic [4:0]       count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;

  // cell row signals
  word_t            vals [DEPTH];
  cell_ctl_t        ctl  [DEPTH];
  logic [DEPTH-1:0] swp, lt_v, eq_v;
  logic [DEPTH:0]   in_list;   // position holds a live element

  logic [DEPTH-1:0] first, ge;
  logic [PW-1:0]    pos;
  logic             hit;

  word_t            rd_vals [RN];

  logic in_xfer, out_free, is_ins, is_rmv, full, phase, idx_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_ins    = op_r inside {OP_SORTED_INS, OP_HEAD_INS, OP_TAIL_INS};
  assign is_rmv    = op_r inside {OP_RMV_VALUE, OP_RMV_HEAD, OP_RMV_TAIL};
  assign full      = (len_r == LW'(DEPTH));
  assign phase     = pass_r[0];
  assign idx_ok    = CW'(idx_r) < CW'(len_r);

  assign out_valid       = out_valid_r;
  assign out_data_out    = $signed(data_r);
  assign out_found       = found_r;
  assign out_where_found = where_r;
  assign out_count       = count_r;
  assign out_status      = status_r;

  // ---- cell row ------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi <= DEPTH; gi++) begin : g_live
      assign in_list[gi] = len_r > LW'(gi);
    end

    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      localparam bit IS_ODD = (gi % 2) == 1;
      word_t left_v, right_v;
      logic  right_s, lo_act, hi_act;

      if (gi == 0) begin : g_head
        assign left_v = '0;
        assign hi_act = 1'b0;
      end else begin : g_mid_l
        assign left_v = vals[gi-1];
        assign hi_act = (IS_ODD != phase) && in_list[gi];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_v = '0;
        assign right_s = 1'b0;
        assign lo_act  = 1'b0;
      end else begin : g_mid_r
        assign right_v = vals[gi+1];
        assign right_s = swp[gi+1];
        assign lo_act  = (IS_ODD == phase) && in_list[gi+1];
      end

      // per-cell update select
      always_comb begin
        ctl[gi].force_swap = (op_r == OP_REVERSE);
        ctl[gi].op         = CELL_HOLD;
        case (state_r)
          S_APPLY: begin
            if (out_free) begin
              if (is_ins && !full && ge[gi]) begin
                ctl[gi].op = first[gi] ? CELL_LOAD : CELL_LEFT;
              end else if (is_rmv && ge[gi]) begin
                ctl[gi].op = CELL_RIGHT;
              end
            end
          end
          S_PASS: begin
            if (lo_act)      ctl[gi].op = CELL_LO;
            else if (hi_act) ctl[gi].op = CELL_HI;
          end
          S_FINISH: begin
            if (out_free && op_r == OP_BUMP) ctl[gi].op = CELL_INC;
          end
          default: ctl[gi].op = CELL_HOLD;
        endcase
      end

      // stop flag: marks where the request acts in this cell's position
      always_comb begin
        case (op_r)
          OP_SORTED_INS: stop_nxt[gi] = !in_list[gi] || !lt_v[gi];
          OP_HEAD_INS:   stop_nxt[gi] = 1'b1;
          OP_TAIL_INS:   stop_nxt[gi] = !in_list[gi];
          OP_RMV_VALUE,
          OP_FIND:       stop_nxt[gi] = in_list[gi] && eq_v[gi];
          OP_RMV_HEAD:   stop_nxt[gi] = (gi == 0) && in_list[gi];
          OP_RMV_TAIL:   stop_nxt[gi] = in_list[gi] && !in_list[gi+1];
          default:       stop_nxt[gi] = 1'b0;
        endcase
      end

      olist_cell u_cell (
        .clk        (clk),
        .ctl        (ctl[gi]),
        .ins_val    (val_r),
        .left_val   (left_v),
        .right_val  (right_v),
        .right_swap (right_s),
        .val        (vals[gi]),
        .swap_req   (swp[gi]),
        .lt_v       (lt_v[gi]),
        .eq_v       (eq_v[gi])
      );
    end

    // read port reaches the first RN positions only
    for (gi = 0; gi < RN; gi++) begin : g_rd
      if (gi < DEPTH) begin : g_on
        assign rd_vals[gi] = vals[gi];
      end else begin : g_off
        assign rd_vals[gi] = '0;
      end
    end
  endgenerate

  olist_locate #(
    .DEPTH (DEPTH)
  ) u_locate (
    .stop  (stop_r),
    .first (first),
    .ge    (ge),
    .pos   (pos),
    .hit   (hit)
  );

  // ---- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    data_nxt      = data_r;
    found_nxt     = found_r;
    where_nxt     = where_r;
    count_nxt     = count_r;
    status_nxt    = status_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        pass_nxt = '0;
        if (is_ins || is_rmv || op_r == OP_FIND) begin
          state_nxt = S_APPLY;
        end else if (op_r == OP_SORT || op_r == OP_REVERSE) begin
          state_nxt = (len_r > LW'(1)) ? S_PASS : S_FINISH;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          data_nxt   = '0;
          found_nxt  = 1'b0;
          where_nxt  = '0;
          status_nxt = ST_OK;
          if (is_ins) begin
            if (full) status_nxt = ST_FULL;
            else      len_nxt    = len_r + LW'(1);
          end else if (hit) begin
            found_nxt = 1'b1;
            where_nxt = 4'(pos);
            if (is_rmv) len_nxt = len_r - LW'(1);
          end else begin
            status_nxt = ST_MISS;
          end
          count_nxt     = 5'(len_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PASS: begin
        pass_nxt = pass_r + LW'(1);
        if (pass_nxt == len_r) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          data_nxt   = '0;
          found_nxt  = 1'b0;
          where_nxt  = '0;
          status_nxt = ST_OK;
          if (op_r == OP_CLEAR) begin
            len_nxt = '0;
          end else if (op_r == OP_READ) begin
            if (idx_ok) begin
              data_nxt  = rd_vals[idx_r];
              found_nxt = 1'b1;
              where_nxt = idx_r;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          count_nxt     = 5'(len_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_operation;
      val_r <= word_t'(in_value);
      idx_r <= in_index;
    end
    if (state_r == S_EVAL) stop_r <= stop_nxt;
    data_r   <= data_nxt;
    found_r  <= found_nxt;
    where_r  <= where_nxt;
    count_r  <= count_nxt;
    status_r <= status_nxt;
  end

endmodule

// File: sim/olist_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_reply_checker
// Watches both channels of the ordered list engine, keeps its own copy of
// the list, predicts one reply per accepted request and compares each reply
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module olist_reply_checker #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_data_out,
  input  logic        out_found,
  input  logic [3:0]  out_where_found,
  input  logic [4:0]  out_count,
  input  logic [1:0]  out_status,
  output int          mismatch_count,
  output int          outstanding
);
  import olist_pkg::*;

  typedef struct {
    word_t      data;
    logic       found;
    logic [3:0] where_found;
    logic [4:0] count;
    logic [1:0] status;
  } list_reply_t;

  word_t       row [DEPTH];
  int          fill;
  list_reply_t expected_replies [$];
  int          errors_seen;

  assign mismatch_count = errors_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors_seen++;
  endtask

  task automatic close_gap(input int pos);
    int k;
    for (k = pos; k + 1 < fill; k++) row[k] = row[k + 1];
    fill--;
  endtask

  // one request applied to the shadow list, reply worked out alongside
  task automatic apply_request(input logic [3:0] op, input word_t v,
                               input logic [3:0] idx, output list_reply_t r);
    int    pos;
    int    i;
    int    k;
    word_t t;
    r = '{data: '0, found: 1'b0, where_found: '0, count: '0, status: ST_OK};
    case (op)
      OP_SORTED_INS, OP_HEAD_INS, OP_TAIL_INS: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_HEAD_INS) begin
            pos = 0;
          end else if (op == OP_TAIL_INS) begin
            pos = fill;
          end else begin
            pos = 0;
            while (pos < fill && $signed(row[pos]) < $signed(v)) pos++;
          end
          for (k = fill; k > pos; k--) row[k] = row[k - 1];
          row[pos] = v;
          fill++;
        end
      end
      OP_RMV_VALUE, OP_FIND: begin
        pos = 0;
        while (pos < fill && row[pos] != v) pos++;
        if (pos < fill) begin
          r.found       = 1'b1;
          r.where_found = pos[3:0];
          if (op == OP_RMV_VALUE) close_gap(pos);
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_RMV_HEAD, OP_RMV_TAIL: begin
        if (fill == 0) begin
          r.status = ST_MISS;
        end else begin
          pos           = (op == OP_RMV_HEAD) ? 0 : fill - 1;
          r.found       = 1'b1;
          r.where_found = pos[3:0];
          close_gap(pos);
        end
      end
      OP_BUMP: begin
        for (i = 0; i < fill; i++) row[i] = row[i] + 32'd1;
      end
      OP_SORT: begin
        for (i = 1; i < fill; i++) begin
          t = row[i];
          k = i;
          while (k > 0 && $signed(t) < $signed(row[k - 1])) begin
            row[k] = row[k - 1];
            k--;
          end
          row[k] = t;
        end
      end
      OP_REVERSE: begin
        for (i = 0, k = fill - 1; i < k; i++, k--) begin
          t      = row[i];
          row[i] = row[k];
          row[k] = t;
        end
      end
      OP_CLEAR: begin
        fill = 0;
      end
      OP_READ: begin
        if (idx < fill) begin
          r.data        = row[idx];
          r.found       = 1'b1;
          r.where_found = idx;
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    r.count = fill[4:0];
  endtask

  always @(posedge clk) begin : watch
    list_reply_t want;
    list_reply_t next;
    if (!rst_n) begin
      fill = 0;
      expected_replies.delete();
    end else begin
      // reply first: it always belongs to an earlier request
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding", 32'(out_count), '0);
        end else begin
          want = expected_replies.pop_front();
          if (out_data_out != want.data)
            report_mismatch("data_out", out_data_out, want.data);
          if (out_found != want.found)
            report_mismatch("found", 32'(out_found), 32'(want.found));
          if (out_where_found != want.where_found)
            report_mismatch("where_found", 32'(out_where_found),
                            32'(want.where_found));
          if (out_count != want.count)
            report_mismatch("count", 32'(out_count), 32'(want.count));
          if (out_status != want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_operation, in_value, in_index, next);
        expected_replies.push_back(next);
      end
    end
    outstanding <= expected_replies.size();
  end

endmodule

// File: sim/ordered_list_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_core_test
// Drives list requests into the ordered list engine under several idling
// patterns and lets the reply checker predict and compare every reply.
// ----------------------------------------------------------------------------
module ordered_list_engine_core_test;
  import olist_pkg::*;

  // codes the package leaves unnamed; the block must treat them as no-ops
  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  // Slowest legal wait for one transfer: a sort of a full list plus the long
  // receiver hold-off below; the limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  // sort of a full list is the longest single request
  localparam int DRAIN_CYCLES   = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_operation;
  logic [31:0] in_value;
  logic [3:0]  in_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_data_out;
  logic        out_found;
  logic [3:0]  out_where_found;
  logic [4:0]  out_count;
  logic [1:0]  out_status;

  int mismatch_count;
  int outstanding;

  // idling knobs, percent of cycles; read by the sender and receiver
  int gap_pct;
  int stall_pct;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_gen;

  ordered_list_engine_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_found      (out_found),
    .out_where_found(out_where_found),
    .out_count      (out_count),
    .out_status     (out_status)
  );

  olist_reply_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_found      (out_found),
    .out_where_found(out_where_found),
    .out_count      (out_count),
    .out_status     (out_status),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Sender: one request per call. Optional idle cycles first, then valid
  // goes up and holds until the transfer edge. Valid is left high on
  // return so back-to-back requests keep it up without a glitch.
  // ---------------------------------------------------------------------
  task automatic send_req(input logic [3:0] op, input logic [31:0] v,
                          input logic [3:0] idx);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    in_index     <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender goes quiet until every predicted reply has come back. The extra
  // edge lets the checker count a request accepted on the current edge.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mix of request codes; insert_pct steers the list toward full or empty.
  function automatic logic [3:0] pick_op(input int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return 4'($urandom_range(OP_SORTED_INS, OP_TAIL_INS));
    r = $urandom_range(0, 99);
    if (r < 14) return OP_RMV_VALUE;
    if (r < 24) return OP_RMV_HEAD;
    if (r < 34) return OP_RMV_TAIL;
    if (r < 50) return OP_FIND;
    if (r < 58) return OP_BUMP;
    if (r < 66) return OP_SORT;
    if (r < 74) return OP_REVERSE;
    if (r < 78) return OP_CLEAR;
    if (r < 94) return OP_READ;
    return 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // Nearly half the values come from a narrow band so find and remove hit often,
  // even after bumps; the rest are full-range or fixed edge values such as the signed extremes.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 52) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'hffff_ffff;
        default: return 32'h7fff_fffe;
      endcase
    end
    return 32'($urandom_range(0, 9)) - 32'd4;
  endfunction

  task automatic run_phase(input int gap, input int stall, input int insert_pct,
                           input int n);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (n) send_req(pick_op(insert_pct), pick_value(), 4'($urandom_range(0, 15)));
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls per stall_pct, plus one long hold-off on
  // request, counted here so the sender keeps pushing while the block fills.
  // ---------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for
  // too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[ordered_list_engine_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------
  initial begin
    gap_pct      = 0;
    stall_pct    = 0;
    hold_gen     = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_FIND;
    in_value     <= '0;
    in_index     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // everything that touches an empty list: misses, and no-op reshapes
    send_req(OP_RMV_VALUE, 32'd5, 4'd0);
    send_req(OP_RMV_HEAD, 32'd0, 4'd0);
    send_req(OP_RMV_TAIL, 32'd0, 4'd0);
    send_req(OP_FIND, 32'd0, 4'd0);
    send_req(OP_READ, 32'd0, 4'd0);
    send_req(OP_SORT, 32'd0, 4'd0);
    send_req(OP_REVERSE, 32'd0, 4'd0);
    send_req(OP_BUMP, 32'd0, 4'd0);
    // sorted inserts at the signed extremes, with a duplicate, then a head and a tail insert
    send_req(OP_SORTED_INS, 32'h7fff_ffff, 4'd0);
    send_req(OP_SORTED_INS, 32'h8000_0000, 4'd0);
    send_req(OP_SORTED_INS, 32'd0, 4'd0);
    send_req(OP_SORTED_INS, 32'd0, 4'd0);
    send_req(OP_HEAD_INS, 32'hffff_ffff, 4'd0);
    send_req(OP_TAIL_INS, 32'h7fff_ffff, 4'd0);
    // first of the duplicates must be reported
    send_req(OP_FIND, 32'd0, 4'd0);
    // max wraps to min
    send_req(OP_BUMP, 32'd0, 4'd0);
    send_req(OP_READ, 32'd0, 4'd0);
    send_req(OP_READ, 32'd0, 4'd15);
    send_req(OP_SORT, 32'd0, 4'd0);
    send_req(OP_REVERSE, 32'd0, 4'd0);
    send_req(OP_RMV_VALUE, 32'd1, 4'd0);
    send_req(OP_RMV_TAIL, 32'd0, 4'd0);
    send_req(OP_SPARE_LO, 32'd0, 4'd0);
    send_req(OP_SPARE_HI, 32'hffff_ffff, 4'hf);
    send_req(OP_CLEAR, 32'd0, 4'd0);
    wait_drained();

    // random phases; insert-heavy first so the list reaches full early
    run_phase(0, 0, 60, 160);
    run_phase(51, 0, 45, 160);
    run_phase(0, 51, 55, 160);
    run_phase(29, 29, 50, 160);

    // long receiver hold-off while the sender keeps offering requests
    gap_pct   = 0;
    stall_pct = 0;
    hold_gen++;
    repeat (80) send_req(pick_op(50), pick_value(), 4'($urandom_range(0, 15)));
    wait_drained();

    // removal-heavy tail to spend time near empty
    run_phase(0, 0, 30, 120);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("[ordered_list_engine_core] OK");
    else
      $display("[ordered_list_engine_core] ERROR");
    $finish;
  end

endmodule
